// ===== rtl/dsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dsu_pkg;

	localparam int NODES_DEF  = 1024;
	localparam int NODE_W     = 10;
	localparam int SIZE_W     = 11;
	localparam int GS_W       = 11;
	localparam int RANK_W     = 4;
	localparam int ACT_W      = 2;

	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
	localparam logic [GS_W-1:0]   GS_RESET = 11'd2;

	localparam logic [ACT_W-1:0] ACT_FIND       = 2'd0;
	localparam logic [ACT_W-1:0] ACT_UNITE_MARK = 2'd1;
	localparam logic [ACT_W-1:0] ACT_UNITE_KEEP = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/disjoint_set_union_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Disjoint-set table with union by rank and path compression.
// Command channel: an item (action, node_a, node_b) transfers on a rising edge
// with start high and busy low. Busy stays high until the result is out.
// Result channel: done is high for one cycle with root, merged, set_size and
// active; the receiver cannot stall, so the result must be taken then.
// All state lives in one single-port-read, single-port-write memory of
// NODES entries (parent, member count, rank, active mark), read registered.
// A find makes one read per step up the path from the node, then one
// read-modify-write per step of the compression walk.
// A unite does this for both nodes, then, if the roots differ, writes the
// link: the lower root first, then the new top root. Before that top write a
// marking unite works out the remainder of the member count by group_size
// (restoring, one bit per cycle) to set the active mark. After reset a
// clearing pass writes every entry, one per cycle, with busy high; group_size
// writes are taken at any time and reset to 2. group_size 0 acts as 1.
module disjoint_set_union_engine_top
	import dsu_pkg::*;
#(
	parameter int NODES = NODES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              group_size_we,
	input  wire logic [GS_W-1:0]   group_size_wdata,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [NODE_W-1:0] node_a,
	input  wire logic [NODE_W-1:0] node_b,
	output logic                   done,
	output logic [NODE_W-1:0]      root,
	output logic                   merged,
	output logic [SIZE_W-1:0]      set_size,
	output logic                   active
);

	localparam int AW  = $clog2(NODES);
	localparam int MW  = $clog2(NODES + 1);
	localparam int DCW = $clog2(MW + 1);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_FRD  = 4'd2;
	localparam logic [3:0] S_FCHK = 4'd3;
	localparam logic [3:0] S_CRD  = 4'd4;
	localparam logic [3:0] S_CCHK = 4'd5;
	localparam logic [3:0] S_LINK = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_TOPW = 4'd8;

	typedef struct packed {
		logic [AW-1:0]     parent;
		logic [MW-1:0]     members;
		logic [RANK_W-1:0] rank;
		logic              act;
	} entry_t;

	function automatic logic [AW-1:0] clamp_node(input logic [NODE_W-1:0] v);
		if (32'(v) >= NODES) clamp_node = AW'(NODES - 1);
		else clamp_node = AW'(v);
	endfunction

	entry_t mem_q [NODES];
	entry_t rdata_q;
	logic [AW-1:0] raddr, waddr;
	entry_t wdata;
	logic we;

	logic [3:0] state_q;
	logic [AW-1:0] clr_q, cur_q, start_q, root_q, ra_q, b_q, top_q;
	logic [ACT_W-1:0] action_q;
	logic phase_q;
	entry_t ea_q, eb_q, te_q;
	logic [GS_W-1:0] gs_q, k_q;
	logic [MW-1:0] dvd_q;
	logic [GS_W-1:0] rem_q;
	logic [DCW-1:0] dcnt_q;

	// link selection
	logic a_low;
	entry_t le, tnew;
	logic [AW-1:0] low_a, top_a;
	logic [GS_W:0] shifted, subbed;
	logic [GS_W-1:0] rem_next;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	always_comb begin
		a_low = ea_q.rank < eb_q.rank;
		low_a = a_low ? ra_q : root_q;
		top_a = a_low ? root_q : ra_q;
		le    = a_low ? ea_q : eb_q;
		tnew  = a_low ? eb_q : ea_q;
		tnew.members = MW'(ea_q.members + eb_q.members);
		if (!a_low && ea_q.rank == eb_q.rank && ea_q.rank < RANK_MAX)
			tnew.rank = ea_q.rank + 1'b1;
		shifted  = {rem_q, dvd_q[MW-1]};
		subbed   = shifted - {1'b0, k_q};
		rem_next = (shifted >= {1'b0, k_q}) ? subbed[GS_W-1:0] : shifted[GS_W-1:0];
	end

	always_comb begin
		raddr = cur_q;
		we    = 1'b0;
		waddr = cur_q;
		wdata = rdata_q;
		case (state_q)
			S_CLR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata.parent = clr_q;
				wdata.members = MW'(1);
				wdata.rank = '0;
				wdata.act = 1'b1;
			end
			S_FCHK: if (rdata_q.parent != cur_q) raddr = rdata_q.parent;
			S_CCHK: if (cur_q != root_q) begin
				we = 1'b1;
				wdata.parent = root_q;
				raddr = rdata_q.parent;
			end
			S_LINK: if (ra_q != root_q) begin
				we = 1'b1;
				waddr = low_a;
				wdata = le;
				wdata.parent = top_a;
			end
			S_TOPW: begin
				we = 1'b1;
				waddr = top_q;
				wdata = te_q;
			end
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gs_q <= GS_RESET;
		else if (group_size_we) gs_q <= group_size_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			phase_q  <= 1'b0;
			done     <= 1'b0;
			dcnt_q   <= '0;
			action_q <= '0;
			cur_q    <= '0;
			start_q  <= '0;
			root_q   <= '0;
			ra_q     <= '0;
			b_q      <= '0;
			top_q    <= '0;
			ea_q     <= '0;
			eb_q     <= '0;
			te_q     <= '0;
			k_q      <= '0;
			dvd_q    <= '0;
			rem_q    <= '0;
			root     <= '0;
			merged   <= 1'b0;
			set_size <= '0;
			active   <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NODES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					action_q <= action;
					cur_q    <= clamp_node(node_a);
					start_q  <= clamp_node(node_a);
					b_q      <= clamp_node(node_b);
					k_q      <= (gs_q == '0) ? GS_W'(1) : gs_q;
					phase_q  <= 1'b0;
					state_q  <= S_FRD;
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (rdata_q.parent == cur_q) begin
						root_q  <= cur_q;
						cur_q   <= start_q;
						state_q <= S_CRD;
					end else begin
						cur_q <= rdata_q.parent;
					end
				end
				S_CRD: state_q <= S_CCHK;
				S_CCHK: begin
					if (cur_q != root_q) begin
						cur_q <= rdata_q.parent;
					end else if (!phase_q) begin
						ea_q <= rdata_q;
						ra_q <= root_q;
						if (action_q != ACT_UNITE_MARK && action_q != ACT_UNITE_KEEP) begin
							done     <= 1'b1;
							root     <= NODE_W'(root_q);
							merged   <= 1'b0;
							set_size <= SIZE_W'(rdata_q.members);
							active   <= rdata_q.act;
							state_q  <= S_IDLE;
						end else begin
							phase_q <= 1'b1;
							cur_q   <= b_q;
							start_q <= b_q;
							state_q <= S_FRD;
						end
					end else begin
						eb_q    <= rdata_q;
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (ra_q == root_q) begin
						done     <= 1'b1;
						root     <= NODE_W'(ra_q);
						merged   <= 1'b0;
						set_size <= SIZE_W'(ea_q.members);
						active   <= ea_q.act;
						state_q  <= S_IDLE;
					end else begin
						top_q <= top_a;
						te_q  <= tnew;
						if (action_q == ACT_UNITE_MARK) begin
							dvd_q   <= tnew.members;
							rem_q   <= '0;
							dcnt_q  <= DCW'(MW);
							state_q <= S_DIV;
						end else begin
							state_q <= S_TOPW;
						end
					end
				end
				S_DIV: begin
					rem_q  <= rem_next;
					dvd_q  <= dvd_q << 1;
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DCW'(1)) begin
						te_q.act <= rem_next != '0;
						state_q  <= S_TOPW;
					end
				end
				S_TOPW: begin
					done     <= 1'b1;
					root     <= NODE_W'(top_q);
					merged   <= 1'b1;
					set_size <= SIZE_W'(te_q.members);
					active   <= te_q.act;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// compression never rewrites the root it points at
	a_root_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CCHK && we) |-> waddr != root_q)
		else $error("compression wrote the root entry");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without work in flight");
`endif

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import dsu_pkg::*;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic              is_cfg;
		logic [GS_W-1:0]   gs;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0] root;
		logic              merged;
		logic [SIZE_W-1:0] size;
		logic              active;
	} res_t;

	localparam int N = NODES_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	logic clk, arst_n;
	logic group_size_we;
	logic [GS_W-1:0] group_size_wdata;
	logic start, busy;
	logic [ACT_W-1:0] action;
	logic [NODE_W-1:0] node_a, node_b;
	logic done, merged, active;
	logic [NODE_W-1:0] root;
	logic [SIZE_W-1:0] set_size;

	disjoint_set_union_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.group_size_we(group_size_we), .group_size_wdata(group_size_wdata),
		.start(start), .busy(busy),
		.action(action), .node_a(node_a), .node_b(node_b),
		.done(done), .root(root), .merged(merged),
		.set_size(set_size), .active(active)
	);

	// shadow of the set table
	logic [NODE_W-1:0] up_link [N];
	logic [SIZE_W+5:0] count [N];
	logic [RANK_W-1:0] rank_of [N];
	logic              mark [N];
	logic [GS_W-1:0]   modulus;

	cmd_t pending [$];
	res_t awaited [$];
	int errors = 0;
	int idle_pct;
	int stall_cycles;
	bit stim_done;
	int quiet;

	function automatic void add_pending(cmd_t c);
		pending = {pending, c};
	endfunction

	function automatic void add_awaited(res_t r);
		awaited = {awaited, r};
	endfunction

	function automatic logic [NODE_W-1:0] walk_to_root(logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] r, cur, nxt;
		r = n;
		while (up_link[r] != r) r = up_link[r];
		cur = n;
		while (cur != r) begin
			nxt = up_link[cur];
			up_link[cur] = r;
			cur = nxt;
		end
		return r;
	endfunction

	function automatic res_t apply_cmd(cmd_t c);
		res_t o;
		logic [NODE_W-1:0] ra, rb, top, low;
		logic [SIZE_W+5:0] k;
		o.merged = 1'b0;
		if (c.act == ACT_UNITE_MARK || c.act == ACT_UNITE_KEEP) begin
			ra = walk_to_root(c.a);
			rb = walk_to_root(c.b);
			o.root = ra;
			if (ra != rb) begin
				if (rank_of[ra] < rank_of[rb]) begin
					top = rb; low = ra;
				end else begin
					top = ra; low = rb;
					if (rank_of[ra] == rank_of[rb] && rank_of[ra] < RANK_MAX)
						rank_of[ra]++;
				end
				up_link[low] = top;
				count[top] = count[top] + count[low];
				if (c.act == ACT_UNITE_MARK) begin
					k = (modulus == '0) ? (SIZE_W+6)'(1) : (SIZE_W+6)'(modulus);
					mark[top] = (count[top] % k) != 0;
				end
				o.root = top;
				o.merged = 1'b1;
			end
		end else begin
			o.root = walk_to_root(c.a);
		end
		o.size = count[o.root][SIZE_W-1:0];
		o.active = mark[o.root];
		return o;
	endfunction

	function automatic cmd_t op(logic [ACT_W-1:0] act, int a, int b);
		cmd_t c;
		c = '0;
		c.act = act;
		c.a = NODE_W'(a);
		c.b = NODE_W'(b);
		return c;
	endfunction

	function automatic cmd_t cfg(int v);
		cmd_t c;
		c = '0;
		c.is_cfg = 1'b1;
		c.gs = GS_W'(v);
		return c;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		int i, base, len;
		arst_n = 0;
		for (i = 0; i < N; i++) begin
			up_link[i] = NODE_W'(i); count[i] = (SIZE_W+6)'(1);
			rank_of[i] = '0; mark[i] = 1'b1;
		end
		// directed part
		add_pending(op(ACT_FIND, 0, 1023));
		add_pending(op(ACT_FIND, 1023, 0));
		add_pending(op(ACT_UNUSED, 5, 6));
		add_pending(op(ACT_UNITE_MARK, 0, 1023));
		add_pending(op(ACT_UNITE_MARK, 1023, 0));
		add_pending(op(ACT_UNITE_KEEP, 1, 2));
		add_pending(op(ACT_UNITE_MARK, 1, 0));
		add_pending(op(ACT_UNITE_MARK, 3, 3));
		add_pending(op(ACT_FIND, 2, 0));
		add_pending(cfg(0));
		add_pending(op(ACT_UNITE_MARK, 10, 11));
		add_pending(cfg(1024));
		add_pending(op(ACT_UNITE_MARK, 12, 13));
		add_pending(op(ACT_UNITE_MARK, 10, 12));
		add_pending(cfg(2047));
		add_pending(op(ACT_UNITE_KEEP, 682, 341));
		add_pending(cfg(3));
		// random part: chains of unites, each followed by one random command on a member, then noise
		for (i = 0; i < 630; ) begin
			if (i % 150 == 100) add_pending(cfg($urandom_range(1, 9)));
			if ($urandom_range(0, 9) < 7) begin
				base = $urandom_range(0, N - 9);
				len = $urandom_range(2, 8);
				repeat (len) begin
					add_pending(op(ACT_W'($urandom_range(1, 2)),
						base + $urandom_range(0, 8), base + $urandom_range(0, 8)));
					i++;
				end
				add_pending(op(ACT_W'($urandom_range(0, 3)), base + $urandom_range(0, 8),
					$urandom_range(0, N - 1)));
				i++;
			end else begin
				add_pending(op(ACT_W'($urandom_range(0, 3)), $urandom_range(0, N - 1),
					$urandom_range(0, N - 1)));
				i++;
			end
		end
		add_pending(cfg(GS_RESET));
		add_pending(op(ACT_UNITE_MARK, 1023, 1022));
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0; action <= '0; node_a <= '0; node_b <= '0;
			group_size_we <= 0; group_size_wdata <= '0;
			stim_done <= 0; stall_cycles <= 0;
			idle_pct <= 28;
			modulus <= GS_RESET;
		end else begin
			stall_cycles <= stall_cycles + 1;
			group_size_we <= 0;
			if (stall_cycles == 3000) idle_pct <= 0;
			if (stall_cycles == 9000) idle_pct <= 28;
			if (start && !busy) begin
				// transfer taken: predict it
				add_awaited(apply_cmd(op(action, node_a, node_b)));
			end
			if (start && busy) begin
				// hold the current item
			end else if (pending.size() == 0) begin
				start <= 0;
				if (!(start && !busy) && awaited.size() == 0) stim_done <= 1;
			end else if (pending[0].is_cfg) begin
				start <= 0;
				if (awaited.size() == 0 && !(start && !busy) && !busy) begin
					group_size_we <= 1;
					group_size_wdata <= pending[0].gs;
					modulus <= pending[0].gs;
					void'(pending.pop_front());
				end
			end else if ($urandom_range(0, 99) < idle_pct) begin
				start <= 0;
			end else begin
				start <= 1;
				action <= pending[0].act;
				node_a <= pending[0].a;
				node_b <= pending[0].b;
				void'(pending.pop_front());
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (awaited.size() == 0) begin
				$error("result with nothing awaited: root %0d", root);
				errors++;
			end else begin
				e = awaited.pop_front();
				if (root !== e.root) begin
					$error("root expected %0d got %0d", e.root, root); errors++;
				end
				if (merged !== e.merged) begin
					$error("merged expected %0d got %0d", e.merged, merged); errors++;
				end
				if (set_size !== e.size) begin
					$error("set_size expected %0d got %0d", e.size, set_size); errors++;
				end
				if (active !== e.active) begin
					$error("active expected %0d got %0d", e.active, active); errors++;
				end
			end
		end
	end

	// watchdog and end of run
	initial begin
		quiet = 0;
		@(posedge arst_n);
		while (!stim_done && quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || group_size_we) quiet = 0;
			else quiet++;
		end
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			repeat (200) @(posedge clk);
			if (errors == 0 && awaited.size() == 0) begin
				$display("simulation ok");
			end else begin
				$display("simulation failed");
			end
			$finish;
		end
	end
endmodule

// ===== files.f =====
rtl/dsu_pkg.sv
rtl/disjoint_set_union_engine_top.sv
sim/testbench.sv
